@@ sv/ethd_pkg.sv @@
`default_nettype none
package ethd_pkg;

    // Default configuration of the angle path
    localparam int DEF_ANGLE_WIDTH   = 32;
    localparam int DEF_CORDIC_STAGES = 24;

    // Q31 datapath: sign, one integer bit, 31 fraction bits
    localparam int Q31_W = 33;
    localparam int XY_W  = 34;
    localparam logic signed [XY_W-1:0] INV_GAIN_Q31 = 34'sh04DBA76D4;
    localparam logic [63:0] TWO_POW63_OVER_PI = 64'h28BE60DB9391054A;

    typedef logic signed [Q31_W-1:0] t_q31;

    // Register map (word index)
    typedef enum logic {
        REG_LATITUDE = 1'b0,
        REG_NONE     = 1'b1
    } t_reg_idx;

    // floor(2^p / d), shift-subtract form, elaboration only
    function automatic logic [63:0] pow2_div(input int p, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[63:0], (j == p) ? 1'b1 : 1'b0};
            if (rem >= {1'b0, d}) begin
                rem    = rem - {1'b0, d};
                quo[j] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in units of 2^-64 turn
    function automatic logic [63:0] atan_turn64(input int i);
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [127:0] prod;
        int           sh;
        sum = '0;
        if (i == 0) begin
            return 64'd1 << 61;
        end
        for (int k = 0; k < 64; k++) begin
            sh = i * (2 * k + 1);
            if (sh >= 62) begin
                break;
            end
            term = pow2_div(62 - sh, 64'(2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        prod = {64'd0, sum} * {64'd0, TWO_POW63_OVER_PI};
        return prod[125:62];
    endfunction

    // Step constant rounded to an aw-bit angle unit
    function automatic logic [63:0] atan_step(input int i, input int aw);
        logic [63:0] half;
        half = 64'd1 << (63 - aw);
        return (atan_turn64(i) + half) >> (64 - aw);
    endfunction

endpackage
`default_nettype wire

@@ sv/ethd_cordic.sv @@
`default_nettype none
module ethd_cordic #(
    parameter int ANGLE_WIDTH   = ethd_pkg::DEF_ANGLE_WIDTH,
    parameter int CORDIC_STAGES = ethd_pkg::DEF_CORDIC_STAGES
) (
    input  wire                i_clk,
    input  wire                i_ce,
    input  wire [31:0]         i_angle,
    output ethd_pkg::t_q31     o_sin,
    output ethd_pkg::t_q31     o_cos
);
    import ethd_pkg::*;

    localparam int AW = ANGLE_WIDTH;
    localparam int N  = CORDIC_STAGES;

    logic [AW+31:0] w_wide;
    logic [AW-1:0]  w_ang;
    logic           w_flip;
    logic [AW-1:0]  w_ang_rot;

    logic signed [XY_W-1:0] r_x    [0:N];
    logic signed [XY_W-1:0] r_y    [0:N];
    logic signed [AW:0]     r_z    [0:N];
    logic                   r_flip [0:N];

    logic signed [XY_W:0] w_xf;
    logic signed [XY_W:0] w_yf;
    t_q31 r_sin;
    t_q31 r_cos;

    // Scale the 32-bit angle to the angle path width
    assign w_wide    = {i_angle, {AW{1'b0}}};
    assign w_ang     = w_wide[AW+31:32];
    // Second and third quadrants: move by half a turn, negate at the end
    assign w_flip    = w_ang[AW-1] ^ w_ang[AW-2];
    assign w_ang_rot = {w_ang[AW-1] ^ w_flip, w_ang[AW-2:0]};

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x[0]    <= INV_GAIN_Q31;
            r_y[0]    <= '0;
            r_z[0]    <= {w_ang_rot[AW-1], w_ang_rot};
            r_flip[0] <= w_flip;
        end
    end

    // One micro-rotation per stage
    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam logic [63:0] STEP64 = atan_step(g, AW);
        localparam logic signed [AW:0] STEP = (AW + 1)'(STEP64);
        logic signed [XY_W-1:0] w_dx;
        logic signed [XY_W-1:0] w_dy;
        assign w_dx = r_y[g] >>> g;
        assign w_dy = r_x[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (!r_z[g][AW]) begin
                    r_x[g+1] <= r_x[g] - w_dx;
                    r_y[g+1] <= r_y[g] + w_dy;
                    r_z[g+1] <= r_z[g] - STEP;
                end else begin
                    r_x[g+1] <= r_x[g] + w_dx;
                    r_y[g+1] <= r_y[g] - w_dy;
                    r_z[g+1] <= r_z[g] + STEP;
                end
                r_flip[g+1] <= r_flip[g];
            end
        end
    end

    // Quadrant fix and clamp to plus or minus one
    assign w_xf = r_flip[N] ? -{r_x[N][XY_W-1], r_x[N]} : {r_x[N][XY_W-1], r_x[N]};
    assign w_yf = r_flip[N] ? -{r_y[N][XY_W-1], r_y[N]} : {r_y[N][XY_W-1], r_y[N]};

    function automatic t_q31 clamp_one(input logic signed [XY_W:0] v);
        if (v > (XY_W + 1)'(64'sd2147483648)) begin
            return Q31_W'(64'sd2147483648);
        end else if (v < -(XY_W + 1)'(64'sd2147483648)) begin
            return -Q31_W'(64'sd2147483648);
        end
        return Q31_W'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_cos <= clamp_one(w_xf);
            r_sin <= clamp_one(w_yf);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
`default_nettype wire

@@ sv/ethd_combine.sv @@
`default_nettype none
module ethd_combine (
    input  wire                  i_clk,
    input  wire                  i_ce,
    input  ethd_pkg::t_q31       i_sin_ha,
    input  ethd_pkg::t_q31       i_cos_ha,
    input  ethd_pkg::t_q31       i_sin_dec,
    input  ethd_pkg::t_q31       i_cos_dec,
    input  ethd_pkg::t_q31       i_sin_lat,
    input  ethd_pkg::t_q31       i_cos_lat,
    output logic signed [31:0]   o_dir_l,
    output logic signed [31:0]   o_dir_m,
    output logic signed [31:0]   o_dir_n
);
    import ethd_pkg::*;

    // Q31 x Q31 rounded back to Q31
    function automatic t_q31 mul_q31(input t_q31 a, input t_q31 b);
        logic signed [2*Q31_W-1:0] p;
        logic signed [2*Q31_W-1:0] r;
        p = a * b;
        r = (p + (2*Q31_W)'(64'sd1073741824)) >>> 31;
        return Q31_W'(r);
    endfunction

    // Q31 rounded to Q30, saturated to plus or minus one
    function automatic logic signed [31:0] pack_q30(input logic signed [Q31_W:0] v);
        logic signed [Q31_W:0] h;
        h = (v + (Q31_W + 1)'(1)) >>> 1;
        if (h > (Q31_W + 1)'(64'sd1073741824)) begin
            return 32'sd1073741824;
        end else if (h < -(Q31_W + 1)'(64'sd1073741824)) begin
            return -32'sd1073741824;
        end
        return 32'(h);
    endfunction

    t_q31 r_t, r_lh, r_cs, r_ss, r_sl, r_cl;
    t_q31 r_slt, r_clt, r_cs2, r_ss2, r_lh2;
    logic signed [Q31_W:0] w_l, w_m, w_n;
    logic signed [31:0] r_l, r_m, r_n;

    // First products
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_t  <= mul_q31(i_cos_dec, i_cos_ha);
            r_lh <= mul_q31(i_cos_dec, i_sin_ha);
            r_cs <= mul_q31(i_cos_lat, i_sin_dec);
            r_ss <= mul_q31(i_sin_lat, i_sin_dec);
            r_sl <= i_sin_lat;
            r_cl <= i_cos_lat;
        end
    end

    // Latitude times cos(dec)cos(ha)
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_slt <= mul_q31(r_sl, r_t);
            r_clt <= mul_q31(r_cl, r_t);
            r_cs2 <= r_cs;
            r_ss2 <= r_ss;
            r_lh2 <= r_lh;
        end
    end

    // Sums and output packing
    assign w_l = -{r_lh2[Q31_W-1], r_lh2};
    assign w_m = {r_cs2[Q31_W-1], r_cs2} - {r_slt[Q31_W-1], r_slt};
    assign w_n = {r_ss2[Q31_W-1], r_ss2} + {r_clt[Q31_W-1], r_clt};

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_l <= pack_q30(w_l);
            r_m <= pack_q30(w_m);
            r_n <= pack_q30(w_n);
        end
    end

    assign o_dir_l = r_l;
    assign o_dir_m = r_m;
    assign o_dir_n = r_n;

endmodule
`default_nettype wire

@@ sv/equatorial_to_horizontal_dircos.sv @@
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_hour_angle, i_declination, i_is_last
// output    out        o_valid / i_stall  o_dir_l, o_dir_m, o_dir_n, o_out_last
// config    in         APB write/read     observer_latitude at byte address 0
//
// One request enters per cycle while o_stall is low; the pipeline stages are
// angle prep, one CORDIC stage per micro-rotation, clamp, two product stages,
// sum and pack.
// Reset (synchronous, active low) clears the valid bits and the latitude.
// A held result with i_stall high freezes the whole pipeline; nothing is lost.
`default_nettype none
module equatorial_to_horizontal_dircos #(
    parameter int ANGLE_WIDTH   = ethd_pkg::DEF_ANGLE_WIDTH,
    parameter int CORDIC_STAGES = ethd_pkg::DEF_CORDIC_STAGES
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire signed [31:0]  i_hour_angle,
    input  wire signed [31:0]  i_declination,
    input  wire                i_is_last,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [31:0] o_dir_l,
    output logic signed [31:0] o_dir_m,
    output logic signed [31:0] o_dir_n,
    output logic               o_out_last,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [2:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ethd_pkg::*;

    localparam int LAT = CORDIC_STAGES + 5;

    logic              w_ce;
    logic [31:0]       r_lat;
    t_reg_idx          w_idx;
    logic [LAT-1:0]    r_vld;
    logic [LAT-1:0]    r_lst;
    t_q31 w_sh, w_ch, w_sd, w_cd, w_sl, w_cl;

    // Config register
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat <= '0;
        end else if (psel && penable && pwrite && w_idx == REG_LATITUDE) begin
            r_lat <= pwdata;
        end
    end

    always_comb begin
        case (w_idx)
            REG_LATITUDE: prdata = r_lat;
            default:      prdata = '0;
        endcase
    end

    // Pipeline advances unless a held result is stalled
    assign w_ce    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_lst <= {r_lst[LAT-2:0], i_is_last};
        end
    end

    // Sine and cosine lanes
    ethd_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_ha (
        .i_clk(i_clk), .i_ce(w_ce), .i_angle(i_hour_angle), .o_sin(w_sh), .o_cos(w_ch)
    );
    ethd_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_dec (
        .i_clk(i_clk), .i_ce(w_ce), .i_angle(i_declination), .o_sin(w_sd), .o_cos(w_cd)
    );
    ethd_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_lat (
        .i_clk(i_clk), .i_ce(w_ce), .i_angle(r_lat), .o_sin(w_sl), .o_cos(w_cl)
    );

    ethd_combine u_combine (
        .i_clk(i_clk), .i_ce(w_ce),
        .i_sin_ha(w_sh), .i_cos_ha(w_ch),
        .i_sin_dec(w_sd), .i_cos_dec(w_cd),
        .i_sin_lat(w_sl), .i_cos_lat(w_cl),
        .o_dir_l(o_dir_l), .o_dir_m(o_dir_m), .o_dir_n(o_dir_n)
    );

    assign o_valid    = r_vld[LAT-1];
    assign o_out_last = r_lst[LAT-1];

endmodule
`default_nettype wire
